### design/mgs_pkg.sv
`timescale 1ns / 1ps
// mgs_pkg: widths, codes, reset values and the queue entry type of the
// motion gesture segmenter. No dependencies.

package mgs_pkg;

	localparam int unsigned COORD_W   = 16;
	localparam int unsigned FRAME_W   = 32;
	localparam int unsigned SPEED_W   = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned EV_W      = 2;
	localparam int unsigned DELTA_W   = COORD_W + 1;
	localparam int unsigned PROD_W    = 2 * DELTA_W;
	localparam int unsigned SQ_W      = 2 * SPEED_W;
	localparam int unsigned LEN2_W    = SQ_W + 2;
	localparam int unsigned Q_DEPTH   = 4;
	localparam int unsigned Q_PTR_W   = $clog2(Q_DEPTH);
	localparam int unsigned Q_CNT_W   = $clog2(Q_DEPTH + 1);

	// event codes
	localparam logic [EV_W-1:0] EV_NONE  = 2'd0;
	localparam logic [EV_W-1:0] EV_START = 2'd1;
	localparam logic [EV_W-1:0] EV_CONT  = 2'd2;
	localparam logic [EV_W-1:0] EV_END   = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_SPEED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END_SPEED   = 2'd1;

	localparam logic [SQ_W-1:0] START_SQ_RST = SQ_W'(50 * 50);
	localparam logic [SQ_W-1:0] END_SQ_RST   = SQ_W'(20 * 20);

	// sample classes decided by the front
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_FIRST = 2'd0;
	localparam kind_t KIND_LOST  = 2'd1;
	localparam kind_t KIND_STEP  = 2'd2;

	typedef struct packed {
		kind_t              kind;
		logic               slow;
		logic               fast;
		logic [FRAME_W-1:0] frame;
	} mgs_entry_t;

endpackage

### design/mgs_in_if.sv
`timescale 1ns / 1ps
// mgs_in_if: sample channel, one tracked-hand point per frame.
// Depends on mgs_pkg.

interface mgs_in_if;
	import mgs_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      hand_present;
	logic signed [COORD_W-1:0] pos_x;
	logic signed [COORD_W-1:0] pos_y;
	logic signed [COORD_W-1:0] pos_z;
	logic [FRAME_W-1:0]        frame_number;

	modport source (output valid, hand_present, pos_x, pos_y, pos_z, frame_number,
		input ready);
	modport sink (input valid, hand_present, pos_x, pos_y, pos_z, frame_number,
		output ready);
endinterface

### design/mgs_out_if.sv
`timescale 1ns / 1ps
// mgs_out_if: event channel, one event per frame.
// Depends on mgs_pkg.

interface mgs_out_if;
	import mgs_pkg::*;

	logic               valid;
	logic               ready;
	logic [EV_W-1:0]    event_res;
	logic [FRAME_W-1:0] first_frame;
	logic [FRAME_W-1:0] current_frame;

	modport source (output valid, event_res, first_frame, current_frame, input ready);
	modport sink (input valid, event_res, first_frame, current_frame, output ready);
endinterface

### design/mgs_cfg_if.sv
`timescale 1ns / 1ps
// mgs_cfg_if: register write channel (index and data).
// Depends on mgs_pkg.

interface mgs_cfg_if;
	import mgs_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] idx;
	logic [SPEED_W-1:0]   wdata;

	modport source (output valid, idx, wdata, input ready);
	modport sink (input valid, idx, wdata, output ready);
endinterface

### design/mgs_front.sv
`timescale 1ns / 1ps
// mgs_front: accepts samples, keeps the previous point, measures the squared
// step in three stages and classifies it. Depends on mgs_pkg, mgs_in_if, mgs_cfg_if.

module mgs_front (
	input  logic               clk,
	input  logic               arst_n,
	mgs_in_if.sink             sample,
	mgs_cfg_if.sink            cfg,
	input  logic               q_full,
	output logic               q_push,
	output mgs_pkg::mgs_entry_t q_entry
);
	import mgs_pkg::*;

	logic [SQ_W-1:0]           start_sq_q;
	logic [SQ_W-1:0]           end_sq_q;
	logic [SQ_W-1:0]           cfg_sq;

	logic signed [COORD_W-1:0] last_x_q;
	logic signed [COORD_W-1:0] last_y_q;
	logic signed [COORD_W-1:0] last_z_q;
	logic                      seen_any_q;
	logic                      last_present_q;

	logic                      adv;
	logic                      accept;
	kind_t                     kind_in;

	logic                      valid_s1;
	kind_t                     kind_s1;
	logic [FRAME_W-1:0]        frame_s1;
	logic signed [DELTA_W-1:0] dx_s1;
	logic signed [DELTA_W-1:0] dy_s1;
	logic signed [DELTA_W-1:0] dz_s1;

	logic signed [PROD_W-1:0]  px;
	logic signed [PROD_W-1:0]  py;
	logic signed [PROD_W-1:0]  pz;

	logic                      valid_s2;
	kind_t                     kind_s2;
	logic [FRAME_W-1:0]        frame_s2;
	logic [SQ_W-1:0]           sqx_s2;
	logic [SQ_W-1:0]           sqy_s2;
	logic [SQ_W-1:0]           sqz_s2;

	logic [LEN2_W-1:0]         len2;
	logic                      valid_s3;
	mgs_entry_t                entry_s3;

	// thresholds are kept squared
	assign cfg.ready = 1'b1;
	assign cfg_sq    = SQ_W'(cfg.wdata) * SQ_W'(cfg.wdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_sq_q <= START_SQ_RST;
			end_sq_q   <= END_SQ_RST;
		end else if (cfg.valid) begin
			unique case (cfg.idx)
				REG_START_SPEED: start_sq_q <= cfg_sq;
				REG_END_SPEED:   end_sq_q   <= cfg_sq;
				default: ;
			endcase
		end
	end

	// whole pipe moves unless stage 3 is blocked by a full queue
	assign adv          = !valid_s3 || !q_full;
	assign sample.ready = adv;
	assign accept       = sample.valid && adv;

	always_comb begin
		if (!seen_any_q)
			kind_in = KIND_FIRST;
		else if (!sample.hand_present || !last_present_q)
			kind_in = KIND_LOST;
		else
			kind_in = KIND_STEP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_any_q     <= 1'b0;
			last_present_q <= 1'b0;
			last_x_q       <= '0;
			last_y_q       <= '0;
			last_z_q       <= '0;
		end else if (accept) begin
			seen_any_q     <= 1'b1;
			last_present_q <= sample.hand_present;
			if (sample.hand_present) begin
				last_x_q <= sample.pos_x;
				last_y_q <= sample.pos_y;
				last_z_q <= sample.pos_z;
			end
		end
	end

	assign px = dx_s1 * dx_s1;
	assign py = dy_s1 * dy_s1;
	assign pz = dz_s1 * dz_s1;

	assign len2 = LEN2_W'(sqx_s2) + LEN2_W'(sqy_s2) + LEN2_W'(sqz_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1  <= kind_in;
			frame_s1 <= sample.frame_number;
			dx_s1    <= DELTA_W'(sample.pos_x) - DELTA_W'(last_x_q);
			dy_s1    <= DELTA_W'(sample.pos_y) - DELTA_W'(last_y_q);
			dz_s1    <= DELTA_W'(sample.pos_z) - DELTA_W'(last_z_q);

			kind_s2  <= kind_s1;
			frame_s2 <= frame_s1;
			// a 17 bit square never exceeds 32 bits
			sqx_s2   <= px[SQ_W-1:0];
			sqy_s2   <= py[SQ_W-1:0];
			sqz_s2   <= pz[SQ_W-1:0];

			entry_s3.kind  <= kind_s2;
			entry_s3.frame <= frame_s2;
			entry_s3.slow  <= len2 < LEN2_W'(end_sq_q);
			entry_s3.fast  <= len2 > LEN2_W'(start_sq_q);
		end
	end

	assign q_push  = valid_s3 && !q_full;
	assign q_entry = entry_s3;

endmodule

### design/mgs_queue.sv
`timescale 1ns / 1ps
// mgs_queue: short fifo of classified samples between front and back.
// Depends on mgs_pkg.

module mgs_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mgs_pkg::mgs_entry_t push_entry,
	output logic                full,
	input  logic                pop,
	output mgs_pkg::mgs_entry_t pop_entry,
	output logic                empty
);
	import mgs_pkg::*;

	mgs_entry_t           slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   cnt_q;

	assign full      = cnt_q == Q_CNT_W'(Q_DEPTH);
	assign empty     = cnt_q == '0;
	assign pop_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### design/mgs_back.sv
`timescale 1ns / 1ps
// mgs_back: gesture state (active, slow step, origin frame) and the event
// output register. Depends on mgs_pkg, mgs_out_if.

module mgs_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	output logic                q_pop,
	input  mgs_pkg::mgs_entry_t q_entry,
	mgs_out_if.source           result
);
	import mgs_pkg::*;

	logic               in_gesture_q;
	logic               slow_prev_q;
	logic [FRAME_W-1:0] origin_q;
	logic               out_valid_q;
	logic [EV_W-1:0]    ev_q;
	logic [FRAME_W-1:0] first_q;
	logic [FRAME_W-1:0] cur_q;

	logic               in_gesture_d;
	logic               slow_prev_d;
	logic [FRAME_W-1:0] origin_d;
	logic [EV_W-1:0]    ev_d;
	logic [FRAME_W-1:0] first_d;

	// output register frees up in the same cycle it is taken
	assign q_pop = !q_empty && (!out_valid_q || result.ready);

	always_comb begin
		in_gesture_d = in_gesture_q;
		slow_prev_d  = slow_prev_q;
		origin_d     = origin_q;
		ev_d         = EV_NONE;
		first_d      = '0;
		unique case (q_entry.kind)
			KIND_LOST: begin
				if (in_gesture_q) begin
					ev_d         = EV_END;
					first_d      = origin_q;
					in_gesture_d = 1'b0;
				end
				slow_prev_d = 1'b0;
			end
			KIND_STEP: begin
				if (in_gesture_q) begin
					first_d = origin_q;
					if (q_entry.slow && slow_prev_q) begin
						ev_d         = EV_END;
						in_gesture_d = 1'b0;
					end else begin
						ev_d = EV_CONT;
					end
				end else if (q_entry.fast) begin
					origin_d     = q_entry.frame - 1'b1;
					first_d      = q_entry.frame - 1'b1;
					in_gesture_d = 1'b1;
					ev_d         = EV_START;
				end
				slow_prev_d = q_entry.slow;
			end
			default: ;  // first sample after reset: no event, no state change
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_gesture_q <= 1'b0;
			slow_prev_q  <= 1'b0;
			origin_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (q_pop) begin
				in_gesture_q <= in_gesture_d;
				slow_prev_q  <= slow_prev_d;
				origin_q     <= origin_d;
				out_valid_q  <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ev_q    <= ev_d;
			first_q <= first_d;
			cur_q   <= q_entry.frame;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.event_res     = ev_q;
	assign result.first_frame   = first_q;
	assign result.current_frame = cur_q;

endmodule

### design/motion_gesture_segmenter_top.sv
`timescale 1ns / 1ps
// motion_gesture_segmenter_top: speed-threshold gesture segmentation of a hand track.
// Depends on mgs_pkg, the channel interfaces, mgs_front, mgs_queue, mgs_back.
//
//   port    dir   contents
//   sample  in    hand_present, pos_x, pos_y, pos_z, frame_number
//   result  out   event_res, first_frame, current_frame
//   cfg     in    idx (0 start_speed, 1 end_speed), wdata
//
// One sample per cycle sustained while result.ready keeps the queue from filling; its
// event becomes valid once the sample has passed the stages (deltas taken at the transfer,
// then squares, compares, the queue and the output register).
// A four-entry queue sits between front and back; sample.ready drops only when
// it is full and the third front stage holds a sample.
// cfg.ready is always high. Reset clears the track and gesture state and loads
// the default thresholds; no clearing pass follows.

module motion_gesture_segmenter_top (
	input  logic       clk,
	input  logic       arst_n,
	mgs_in_if.sink     sample,
	mgs_out_if.source  result,
	mgs_cfg_if.sink    cfg
);
	import mgs_pkg::*;

	logic       q_push;
	logic       q_pop;
	logic       q_full;
	logic       q_empty;
	mgs_entry_t push_entry;
	mgs_entry_t pop_entry;

	mgs_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample),
		.cfg     (cfg),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_entry (push_entry)
	);

	mgs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.pop_entry  (pop_entry),
		.empty      (q_empty)
	);

	mgs_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.q_entry (pop_entry),
		.result  (result)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue push while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue pop while empty");

	a_pop_shows: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> result.valid)
		else $error("popped sample did not reach the output register");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.event_res == EV_NONE) |-> result.first_frame == '0)
		else $error("first_frame nonzero on a none event");

endmodule

### verif/mgs_event_checker.sv
`timescale 1ns / 1ps
// mgs_event_checker: watches the sample, result and cfg channels of the gesture segmenter,
// predicts one event per sample and compares each result transfer in order.
// Depends on mgs_pkg, mgs_in_if, mgs_out_if and mgs_cfg_if.

module mgs_event_checker (
	input  logic clk,
	input  logic arst_n,
	mgs_in_if    sample,
	mgs_out_if   result,
	mgs_cfg_if   cfg,
	output int   fail_count,
	output int   pending
);
	import mgs_pkg::*;

	localparam logic [SPEED_W-1:0] START_SPEED_RST = 16'd50;
	localparam logic [SPEED_W-1:0] END_SPEED_RST   = 16'd20;
	localparam int                 MAX_REPORTS     = 10;

	typedef struct packed {
		logic [EV_W-1:0]    ev;
		logic [FRAME_W-1:0] first;
		logic [FRAME_W-1:0] cur;
	} seg_event_t;

	seg_event_t events_due[$];

	logic [SPEED_W-1:0]        start_thr;
	logic [SPEED_W-1:0]        end_thr;
	logic signed [COORD_W-1:0] prev_x;
	logic signed [COORD_W-1:0] prev_y;
	logic signed [COORD_W-1:0] prev_z;
	logic                      prev_present;
	logic                      primed;
	logic                      active;
	logic                      prev_slow;
	logic [FRAME_W-1:0]        origin;

	// advances the track state by one frame and returns its event
	function automatic seg_event_t segment_frame(input logic present,
		input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y,
		input logic signed [COORD_W-1:0] z, input logic [FRAME_W-1:0] frame);
		seg_event_t                e;
		logic signed [DELTA_W-1:0] dx, dy, dz;
		logic signed [PROD_W-1:0]  qx, qy, qz;
		logic [LEN2_W-1:0]         len2;
		logic [SQ_W-1:0]           start_sq, end_sq;
		logic                      slow;
		e.ev = EV_NONE;
		e.first = '0;
		e.cur = frame;
		if (primed) begin
			if (!present || !prev_present) begin
				// hand lost: no step, an open gesture closes
				if (active) begin
					e.ev = EV_END;
					e.first = origin;
					active = 1'b0;
				end
				prev_slow = 1'b0;
			end else begin
				dx = x - prev_x;
				dy = y - prev_y;
				dz = z - prev_z;
				qx = dx * dx;
				qy = dy * dy;
				qz = dz * dz;
				len2 = qx + qy + qz;
				start_sq = start_thr * start_thr;
				end_sq = end_thr * end_thr;
				slow = (len2 < end_sq);
				if (active) begin
					e.first = origin;
					if (slow && prev_slow) begin
						e.ev = EV_END;
						active = 1'b0;
					end else begin
						e.ev = EV_CONT;
					end
				end else if (len2 > start_sq) begin
					// origin is the frame before the start frame, wrapping at zero
					origin = frame - 1'b1;
					e.first = origin;
					e.ev = EV_START;
					active = 1'b1;
				end
				prev_slow = slow;
			end
		end
		primed = 1'b1;
		prev_present = present;
		if (present) begin
			prev_x = x;
			prev_y = y;
			prev_z = z;
		end
		return e;
	endfunction

	task automatic flag_error(input string msg);
		if (fail_count < MAX_REPORTS)
			$display("%0t ns: %s", $time, msg);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		seg_event_t want;
		seg_event_t got;
		if (!arst_n) begin
			start_thr = START_SPEED_RST;
			end_thr = END_SPEED_RST;
			prev_x = '0;
			prev_y = '0;
			prev_z = '0;
			prev_present = 1'b0;
			primed = 1'b0;
			active = 1'b0;
			prev_slow = 1'b0;
			origin = '0;
			fail_count = 0;
			events_due.delete();
			pending <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.idx)
					REG_START_SPEED: start_thr = cfg.wdata;
					REG_END_SPEED:   end_thr = cfg.wdata;
					default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				got.ev = result.event_res;
				got.first = result.first_frame;
				got.cur = result.current_frame;
				if (events_due.size() == 0) begin
					flag_error($sformatf("unexpected event %0d first %0h frame %0h",
						got.ev, got.first, got.cur));
				end else begin
					want = events_due.pop_front();
					if (got.ev !== want.ev)
						flag_error($sformatf("frame %0h event_res: expected %0d, got %0d",
							want.cur, want.ev, got.ev));
					if (got.first !== want.first)
						flag_error($sformatf("frame %0h first_frame: expected %0h, got %0h",
							want.cur, want.first, got.first));
					if (got.cur !== want.cur)
						flag_error($sformatf("current_frame: expected %0h, got %0h",
							want.cur, got.cur));
				end
			end
			if (sample.valid && sample.ready)
				events_due.insert(events_due.size(), segment_frame(sample.hand_present,
					sample.pos_x, sample.pos_y, sample.pos_z, sample.frame_number));
			pending <= events_due.size();
		end
	end

endmodule

### verif/motion_gesture_segmenter_top_tb.sv
`timescale 1ns / 1ps
// motion_gesture_segmenter_top_tb: drives hand tracks and threshold writes into the
// gesture segmenter and gives the verdict. Depends on mgs_pkg, the channel interfaces,
// motion_gesture_segmenter_top and mgs_event_checker.

module motion_gesture_segmenter_top_tb;
	import mgs_pkg::*;

	localparam int SETTLE_CYCLES = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   pending;
	int   tx_idle_pct;
	int   rx_idle_pct;

	logic [SPEED_W-1:0]        start_cfg;
	logic [SPEED_W-1:0]        end_cfg;
	logic signed [COORD_W-1:0] hand_x, hand_y, hand_z;
	logic [FRAME_W-1:0]        frame_ctr;

	mgs_in_if  sample ();
	mgs_out_if result ();
	mgs_cfg_if cfg ();

	motion_gesture_segmenter_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.result (result),
		.cfg    (cfg)
	);

	mgs_event_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (sample),
		.result     (result),
		.cfg        (cfg),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		result.ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	initial begin
		#2ms;
		$display("Verification failed");
		$finish;
	end

	task automatic put_sample(input logic present, input logic signed [COORD_W-1:0] x,
		input logic signed [COORD_W-1:0] y, input logic signed [COORD_W-1:0] z,
		input logic [FRAME_W-1:0] frame);
		while ($urandom_range(99) < tx_idle_pct) begin
			sample.valid <= 1'b0;
			@(posedge clk);
		end
		sample.valid <= 1'b1;
		sample.hand_present <= present;
		sample.pos_x <= x;
		sample.pos_y <= y;
		sample.pos_z <= z;
		sample.frame_number <= frame;
		@(posedge clk);
		while (!sample.ready) @(posedge clk);
	endtask

	// hold the sender until every event is out, then let the pipeline settle
	task automatic wait_quiet();
		sample.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_thresholds(input logic [SPEED_W-1:0] fast_thr,
		input logic [SPEED_W-1:0] slow_thr);
		wait_quiet();
		cfg.valid <= 1'b1;
		cfg.idx <= REG_START_SPEED;
		cfg.wdata <= fast_thr;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.idx <= REG_END_SPEED;
		cfg.wdata <= slow_thr;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		start_cfg = fast_thr;
		end_cfg = slow_thr;
	endtask

	function automatic logic signed [COORD_W-1:0] clamp_coord(input int v);
		if (v > 32767)
			return 16'sh7FFF;
		if (v < -32768)
			return 16'sh8000;
		return COORD_W'(v);
	endfunction

	// random walk of the hand; step size picked around the current thresholds
	task automatic run_track(input int n);
		int k;
		int mode;
		int span;
		for (k = 0; k < n; k++) begin
			if (k == n / 2)
				wait_quiet();
			mode = $urandom_range(9);
			case (mode)
				1, 2:    span = end_cfg / 2;
				3, 4:    span = end_cfg;
				5, 6:    span = start_cfg;
				default: span = 2 * start_cfg + 1;
			endcase
			if (mode == 0 || mode == 9) begin
				hand_x = COORD_W'($urandom);
				hand_y = COORD_W'($urandom);
				hand_z = COORD_W'($urandom);
			end else begin
				hand_x = clamp_coord(hand_x + int'($urandom_range(2 * span)) - span);
				hand_y = clamp_coord(hand_y + int'($urandom_range(2 * span)) - span);
				hand_z = clamp_coord(hand_z + int'($urandom_range(2 * span)) - span);
			end
			if ($urandom_range(49) == 0)
				frame_ctr = $urandom;
			else
				frame_ctr = frame_ctr + 1'b1;
			put_sample(mode != 0, hand_x, hand_y, hand_z, frame_ctr);
		end
	endtask

	initial begin
		sample.valid <= 1'b0;
		sample.hand_present <= 1'b0;
		sample.pos_x <= '0;
		sample.pos_y <= '0;
		sample.pos_z <= '0;
		sample.frame_number <= '0;
		cfg.valid <= 1'b0;
		cfg.idx <= REG_START_SPEED;
		cfg.wdata <= '0;
		start_cfg = 16'd50;
		end_cfg = 16'd20;
		hand_x = '0;
		hand_y = '0;
		hand_z = '0;
		frame_ctr = $urandom;
		tx_idle_pct = 38;
		rx_idle_pct = 75;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset thresholds: first frame, start at frame zero, two slow steps end
		put_sample(1'b1, 16'sd0, 16'sd0, 16'sd0, 32'd0);
		put_sample(1'b1, 16'sd100, 16'sd0, 16'sd0, 32'd0);
		put_sample(1'b1, 16'sd100, 16'sd0, 16'sd0, 32'd1);
		put_sample(1'b1, 16'sd101, 16'sd0, 16'sd0, 32'd2);
		// step exactly at the start threshold does not start, one above does
		put_sample(1'b1, 16'sd101, 16'sd0, 16'sd50, 32'd3);
		put_sample(1'b1, 16'sd101, 16'sd0, 16'sd101, 32'd4);
		put_sample(1'b1, 16'sd101, 16'sd0, 16'sd101, 32'd5);
		// step exactly at the end threshold is not slow
		put_sample(1'b1, 16'sd121, 16'sd0, 16'sd101, 32'd6);
		put_sample(1'b1, 16'sd121, 16'sd0, 16'sd101, 32'd7);
		// hand lost while active, then absent again
		put_sample(1'b0, 16'shFFFF, 16'shFFFF, 16'shFFFF, 32'd8);
		put_sample(1'b0, 16'sd0, 16'sd0, 16'sd0, 32'd9);
		put_sample(1'b1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'd10);
		// longest possible step, then frame numbers out of order
		put_sample(1'b1, 16'sh8000, 16'sh8000, 16'sh8000, 32'd11);
		put_sample(1'b1, 16'sh8000, 16'sh8000, 16'sh8000, 32'hFFFF_FFFF);
		put_sample(1'b1, 16'sh8000, 16'sh8000, 16'sh8000, 32'd0);
		put_sample(1'b1, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 32'd12345);
		put_sample(1'b0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'd12346);
		put_sample(1'b1, 16'sd0, 16'sd0, 16'sd0, 32'd12347);
		put_sample(1'b1, 16'sd0, 16'sd0, 16'sd0, 32'h8000_0000);
		run_track(140);

		// start below end: the start step already counts as slow
		set_thresholds(16'd5, 16'd30);
		hand_x = '0;
		hand_y = '0;
		hand_z = '0;
		put_sample(1'b1, 16'sd0, 16'sd0, 16'sd0, 32'd100);
		put_sample(1'b1, 16'sd0, 16'sd0, 16'sd0, 32'd101);
		put_sample(1'b1, 16'sd10, 16'sd0, 16'sd0, 32'd102);
		put_sample(1'b1, 16'sd12, 16'sd0, 16'sd0, 32'd103);
		run_track(120);

		tx_idle_pct = 75;
		rx_idle_pct = 38;
		set_thresholds(16'hFFFF, 16'h0000);
		run_track(80);
		set_thresholds(16'h0000, 16'hFFFF);
		run_track(80);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_thresholds(16'($urandom_range(200)), 16'($urandom_range(200)));
		run_track(100);
		set_thresholds(16'h0000, 16'h0000);
		run_track(60);

		wait_quiet();
		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
